// ===== src/cmne_pkg.sv =====
`timescale 1ns / 1ps

package cmne_pkg;

    localparam int MAP_ENTRIES = 65536;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);
    localparam int IDX_W       = 16;
    localparam int VAL_W       = 8;
    localparam int BITS_W      = 20;
    localparam int BYTES_W     = 17;
    localparam int BIT_CNT_W   = $clog2(MAP_ENTRIES * 8 + 1);
    localparam int BYTE_CNT_W  = $clog2(MAP_ENTRIES + 1);

    typedef logic [MAP_AW-1:0]     t_addr;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [VAL_W-1:0]      t_byte;
    typedef logic [BITS_W-1:0]     t_bits;
    typedef logic [BYTES_W-1:0]    t_bytes;
    typedef logic [BIT_CNT_W-1:0]  t_bit_cnt;
    typedef logic [BYTE_CNT_W-1:0] t_byte_cnt;
    typedef logic [3:0]            t_ones;

    localparam t_byte  BYTE_ALL  = '1;
    localparam t_bits  BITS_MAX  = '1;
    localparam t_bytes BYTES_MAX = '1;

    typedef enum logic {
        ACT_TRACE = 1'b0,
        ACT_MERGE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_BUCKET = 2'd1,
        VERDICT_TUPLE  = 2'd2
    } t_verdict;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_byte wdata;
        logic  re;
        t_addr raddr;
    } t_map_req;

    function automatic t_byte bucket_of(t_byte hits);
        t_byte b;
        if (hits < 8'd3) begin
            b = hits;
        end else if (hits == 8'd3) begin
            b = 8'd4;
        end else if (hits < 8'd8) begin
            b = 8'd8;
        end else if (hits < 8'd16) begin
            b = 8'd16;
        end else if (hits < 8'd32) begin
            b = 8'd32;
        end else if (hits < 8'd128) begin
            b = 8'd64;
        end else begin
            b = 8'd128;
        end
        return b;
    endfunction

    function automatic t_ones ones_in(t_byte v);
        t_ones n;
        n = '0;
        for (int k = 0; k < VAL_W; k++) begin
            n = n + t_ones'(v[k]);
        end
        return n;
    endfunction

endpackage

// ===== src/cmne_if.sv =====
`timescale 1ns / 1ps

interface cmne_in_if;
    logic             valid;
    logic             ready;
    cmne_pkg::t_action action;
    cmne_pkg::t_idx    map_index;
    cmne_pkg::t_byte   value;
    logic             last;

    modport source (output valid, output action, output map_index, output value,
                    output last, input ready);
    modport sink (input valid, input action, input map_index, input value,
                  input last, output ready);
endinterface

interface cmne_out_if;
    logic               valid;
    logic               ready;
    cmne_pkg::t_verdict verdict;
    cmne_pkg::t_bits    touched_bits;
    cmne_pkg::t_bytes   touched_bytes;

    modport source (output valid, output verdict, output touched_bits,
                    output touched_bytes, input ready);
    modport sink (input valid, input verdict, input touched_bits,
                  input touched_bytes, output ready);
endinterface

// ===== src/coverage_map_novelty_engine.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Fields                                     Transaction
// i_in     in   action, map_index, value, last             one trace or merge item
// o_out    out  verdict, touched_bits, touched_bytes       one result per last item
//
// One item per cycle unless stalled: a map entry is read at acceptance and written back
// from the update stage; back-to-back items on one entry are forwarded.
// After reset a clearing pass writes all 65536 map entries, one per cycle, before the first
// transaction on i_in is taken. Results wait in an output register; beyond clearing,
// input stalls only when a last item finds the output register still full.

module coverage_map_novelty_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cmne_in_if.sink         i_in,
    cmne_out_if.source      o_out
);
    import cmne_pkg::*;

    t_map_req  w_req;
    t_byte     w_rd_data;
    logic      w_busy;

    logic      r_s1_valid;
    t_action   r_s1_action;
    t_idx      r_s1_idx;
    t_byte     r_s1_value;
    logic      r_s1_last;

    logic      r_fwd_valid;
    t_addr     r_fwd_addr;
    t_byte     r_fwd_data;

    t_verdict  r_verdict;
    t_verdict  n_verdict;
    t_bit_cnt  r_bit_cnt;
    t_bit_cnt  n_bit_cnt;
    t_byte_cnt r_byte_cnt;
    t_byte_cnt n_byte_cnt;

    logic      r_out_valid;
    t_verdict  r_out_verdict;
    t_bits     r_out_bits;
    t_bytes    r_out_bytes;

    logic      w_accept;
    logic      w_s1_adv;
    logic      w_fire;
    t_addr     w_s1_addr;
    t_byte     w_cur;
    t_byte     w_new;
    t_byte     w_bucket;
    logic      w_in_range;
    logic      w_we;
    t_ones     w_bit_delta;
    t_bits     w_bits_sat;
    t_bytes    w_bytes_sat;

    cmne_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data),
        .o_busy    (w_busy)
    );

    assign w_s1_adv   = !(r_s1_last && r_out_valid && !o_out.ready);
    assign w_fire     = r_s1_valid && w_s1_adv;
    assign i_in.ready = !w_busy && (!r_s1_valid || w_s1_adv);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_s1_addr  = t_addr'(r_s1_idx);

    always_comb begin
        w_in_range = (32'(r_s1_idx) < MAP_ENTRIES);
        w_cur      = (r_fwd_valid && (r_fwd_addr == w_s1_addr)) ? r_fwd_data : w_rd_data;
        w_bucket   = bucket_of(r_s1_value);
        w_new      = w_cur;
        w_we       = 1'b0;
        n_verdict  = r_verdict;
        if (r_s1_valid && w_in_range) begin
            if (r_s1_action == ACT_TRACE) begin
                if ((w_bucket & w_cur) != '0) begin
                    w_we  = 1'b1;
                    w_new = w_cur & ~w_bucket;
                    if (w_cur == BYTE_ALL) begin
                        n_verdict = VERDICT_TUPLE;
                    end else if (r_verdict == VERDICT_NONE) begin
                        n_verdict = VERDICT_BUCKET;
                    end
                end
            end else begin
                w_we  = 1'b1;
                w_new = w_cur & r_s1_value;
            end
        end

        w_bit_delta = ones_in(w_cur) - ones_in(w_new);
        n_bit_cnt   = r_bit_cnt;
        n_byte_cnt  = r_byte_cnt;
        if (w_we) begin
            n_bit_cnt = r_bit_cnt + t_bit_cnt'(w_bit_delta);
            if (w_cur == BYTE_ALL && w_new != BYTE_ALL) begin
                n_byte_cnt = r_byte_cnt + t_byte_cnt'(1);
            end
        end

        w_bits_sat  = (32'(n_bit_cnt) > 32'(BITS_MAX)) ? BITS_MAX : t_bits'(n_bit_cnt);
        w_bytes_sat = (32'(n_byte_cnt) > 32'(BYTES_MAX)) ? BYTES_MAX : t_bytes'(n_byte_cnt);

        w_req.we    = w_we && w_fire;
        w_req.waddr = w_s1_addr;
        w_req.wdata = w_new;
        w_req.re    = w_accept;
        w_req.raddr = t_addr'(i_in.map_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_verdict   <= VERDICT_NONE;
            r_bit_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (w_busy) begin
                r_fwd_valid <= 1'b0;
            end else if (w_req.we) begin
                r_fwd_valid <= 1'b1;
            end

            if (w_fire) begin
                r_verdict  <= r_s1_last ? VERDICT_NONE : n_verdict;
                r_bit_cnt  <= n_bit_cnt;
                r_byte_cnt <= n_byte_cnt;
            end

            if (w_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action <= i_in.action;
            r_s1_idx    <= i_in.map_index;
            r_s1_value  <= i_in.value;
            r_s1_last   <= i_in.last;
        end
        if (w_req.we) begin
            r_fwd_addr <= w_req.waddr;
            r_fwd_data <= w_req.wdata;
        end
        if (w_fire && r_s1_last) begin
            r_out_verdict <= n_verdict;
            r_out_bits    <= w_bits_sat;
            r_out_bytes   <= w_bytes_sat;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.verdict       = r_out_verdict;
    assign o_out.touched_bits  = r_out_bits;
    assign o_out.touched_bytes = r_out_bytes;

    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_busy |-> !i_in.ready
    ) else $error("Input transaction offered during map clearing pass.");

    a_write_needs_item: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_req.we |-> (r_s1_valid && !w_busy)
    ) else $error("Map write without an item in the update stage.");

    a_result_from_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && !w_s1_adv) |=> (r_s1_valid && r_out_valid)
    ) else $error("Stalled last item lost its place.");

    a_bits_monotonic: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_bit_cnt >= $past(r_bit_cnt))
    ) else $error("Touched bit count decreased.");

    a_bytes_bounded_by_bits: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        32'(r_byte_cnt) <= 32'(r_bit_cnt)
    ) else $error("Touched byte count exceeds touched bit count.");

endmodule

// ===== src/cmne_map.sv =====
`timescale 1ns / 1ps

module cmne_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmne_pkg::t_map_req i_req,
    output cmne_pkg::t_byte    o_rd_data,
    output logic               o_busy
);
    import cmne_pkg::*;

    typedef enum logic [1:0] {
        MAP_CLEAR = 2'b01,
        MAP_RUN   = 2'b10
    } t_map_state;

    t_byte      r_mem [MAP_ENTRIES];
    t_byte      r_rd_data;
    t_map_state r_state;
    t_map_state n_state;
    t_addr      r_clr_addr;
    t_addr      n_clr_addr;
    logic       w_we;
    t_addr      w_waddr;
    t_byte      w_wdata;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        w_we       = 1'b0;
        w_waddr    = i_req.waddr;
        w_wdata    = i_req.wdata;
        case (r_state)
            MAP_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = BYTE_ALL;
                n_clr_addr = r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(MAP_ENTRIES - 1)) begin
                    n_state = MAP_RUN;
                end
            end
            MAP_RUN: begin
                w_we = i_req.we;
            end
            default: begin
                n_state = MAP_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= MAP_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = (r_state != MAP_RUN);

endmodule
